// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the frame builder
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CFB_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("cfb assertion failed");
`define CFB_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("cfb forbidden condition seen");
`else
`define CFB_ASSERT(lbl, clk, rst_n, prop)
`define CFB_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/cfb_pkg.sv =====
// types and constants of the checksummed frame builder
// used by every module of the block; no dependencies
package cfb_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND = 8'hAA;
	localparam logic [7:0] LEN_EXTRA   = 8'd2;

	typedef struct packed {
		logic [7:0] dest_addr;
		logic [7:0] command;
		logic [7:0] register_id;
		logic [7:0] payload_count;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_item;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} out_item_t;

	// classified item as queued between front and back
	typedef struct packed {
		logic       first;
		logic [7:0] len_byte;
		logic [7:0] dest_addr;
		logic [7:0] command;
		logic [7:0] register_id;
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_item;
	} qent_t;

	typedef enum logic [3:0] {
		ST_START,
		ST_SYNC1,
		ST_SYNC2,
		ST_LEN,
		ST_DEST,
		ST_CMD,
		ST_REG,
		ST_DATA,
		ST_CK_LO,
		ST_CK_HI,
		ST_DONE
	} phase_t;

endpackage

// ===== rtl/cfb_front.sv =====
// front end: accepts items, tracks frame start, clamps the length byte
// depends on cfb_pkg
module cfb_front #(
	parameter int MAX_PAYLOAD = 253
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  cfb_pkg::in_item_t item,
	output logic             push,
	output cfb_pkg::qent_t   push_ent,
	input  logic             q_full
);
	import cfb_pkg::*;

	logic       in_frame_q;
	logic [7:0] count_clamped;

	assign item_stall = q_full;
	assign push = item_valid & ~q_full;

	assign count_clamped = (item.payload_count > 8'(MAX_PAYLOAD)) ?
		8'(MAX_PAYLOAD) : item.payload_count;

	always_comb begin
		push_ent.first       = ~in_frame_q;
		push_ent.len_byte    = count_clamped + LEN_EXTRA;
		push_ent.dest_addr   = item.dest_addr;
		push_ent.command     = item.command;
		push_ent.register_id = item.register_id;
		push_ent.data_byte   = item.data_byte;
		push_ent.has_byte    = item.has_byte;
		push_ent.last_item   = item.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= ~item.last_item;
		end
	end

endmodule

// ===== rtl/cfb_queue.sv =====
// short register queue between the front end and the frame sequencer
// depends on cfb_pkg and assert_macros.svh
`include "assert_macros.svh"
module cfb_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfb_pkg::qent_t push_ent,
	input  logic           pop,
	output cfb_pkg::qent_t head,
	output logic           nempty,
	output logic           full
);
	import cfb_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t          ent_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign head   = ent_q[rd_ptr_q];
	assign nempty = (cnt_q != '0);
	assign full   = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CFB_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(DEPTH))
	`CFB_NEVER(a_pop_empty, clk, arst_n, pop && !nempty)

endmodule

// ===== rtl/cfb_back.sv =====
// back end: walks each queued item through header, payload and checksum bytes
// depends on cfb_pkg and assert_macros.svh
`include "assert_macros.svh"
module cfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_we,
	input  logic [7:0]        key_wdata,
	input  cfb_pkg::qent_t    head,
	input  logic              nempty,
	output logic              pop,
	output logic              frame_valid,
	input  logic              frame_stall,
	output cfb_pkg::out_item_t frame
);
	import cfb_pkg::*;

	phase_t     ph_q;
	phase_t     ph;
	phase_t     ph_after;
	phase_t     ph_nxt;
	logic [7:0] key_q;
	logic [15:0] sum_q;
	logic [15:0] csum;
	logic       adv;
	logic       emit;
	logic       load;
	logic       summed;
	logic       is_end;
	logic [7:0] clear;
	logic       out_valid_q;
	out_item_t  out_q;

	assign adv = ~out_valid_q | ~frame_stall;
	assign csum = ~sum_q;

	// next state
	always_comb begin
		if (ph_q != ST_START) begin
			ph = ph_q;
		end else if (head.first) begin
			ph = ST_SYNC1;
		end else if (head.has_byte) begin
			ph = ST_DATA;
		end else if (head.last_item) begin
			ph = ST_CK_LO;
		end else begin
			ph = ST_DONE;
		end

		case (ph)
			ST_SYNC1: ph_after = ST_SYNC2;
			ST_SYNC2: ph_after = ST_LEN;
			ST_LEN:   ph_after = ST_DEST;
			ST_DEST:  ph_after = ST_CMD;
			ST_CMD:   ph_after = ST_REG;
			ST_REG: begin
				if (head.has_byte) begin
					ph_after = ST_DATA;
				end else if (head.last_item) begin
					ph_after = ST_CK_LO;
				end else begin
					ph_after = ST_DONE;
				end
			end
			ST_DATA:  ph_after = head.last_item ? ST_CK_LO : ST_DONE;
			ST_CK_LO: ph_after = ST_CK_HI;
			default:  ph_after = ST_DONE;
		endcase

		ph_nxt = ph_q;
		pop    = 1'b0;
		if (nempty) begin
			if (ph == ST_DONE || (adv && ph_after == ST_DONE)) begin
				pop    = 1'b1;
				ph_nxt = ST_START;
			end else if (adv) begin
				ph_nxt = ph_after;
			end
		end
	end

	// outputs
	always_comb begin
		clear  = '0;
		summed = 1'b0;
		is_end = 1'b0;
		emit   = nempty;
		case (ph)
			ST_SYNC1: clear = SYNC_FIRST;
			ST_SYNC2: clear = SYNC_SECOND;
			ST_LEN: begin
				clear  = head.len_byte;
				summed = 1'b1;
			end
			ST_DEST: begin
				clear  = head.dest_addr;
				summed = 1'b1;
			end
			ST_CMD: begin
				clear  = head.command;
				summed = 1'b1;
			end
			ST_REG: begin
				clear  = head.register_id;
				summed = 1'b1;
			end
			ST_DATA: begin
				clear  = head.data_byte;
				summed = 1'b1;
			end
			ST_CK_LO: clear = csum[7:0];
			ST_CK_HI: begin
				clear  = csum[15:8];
				is_end = 1'b1;
			end
			default: emit = 1'b0;
		endcase
		load = emit & adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= ST_START;
			key_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			ph_q <= ph_nxt;
			if (key_we) begin
				key_q <= key_wdata;
			end
			if (load && summed) begin
				sum_q <= ((ph == ST_LEN) ? 16'd0 : sum_q) + {8'd0, clear};
			end
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.frame_byte <= clear ^ key_q;
			out_q.frame_end  <= is_end;
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	`CFB_ASSERT(a_end_closes, clk, arst_n, (load && ph == ST_CK_HI) |=> ph_q == ST_START)
	`CFB_ASSERT(a_mid_has_head, clk, arst_n, (ph_q != ST_START) |-> nempty)

endmodule

// ===== rtl/checksummed_frame_builder.sv =====
// checksummed request frame builder, top level
// item channel in, frame byte channel out, one key register
// depends on cfb_pkg, cfb_front, cfb_queue, cfb_back
//
// item / item_valid / item_stall: one item per handshake; the first item of a
// frame carries the header fields, has_byte marks a payload byte, last_item
// closes the frame. frame / frame_valid / frame_stall: one frame byte per
// handshake, frame_end on the checksum high byte. key_we / key_wdata load
// the xor key; the user must write it only while the block is idle, and the
// block does not enforce it. an item is queued, then its first byte leaves
// the single output register. a frame start emits six header bytes, a
// payload item one byte, the last item two checksum bytes, each at one byte
// per cycle unless stalled, so payload items stream at one per cycle.
// header and checksum bursts fill the QUEUE_DEPTH entry queue; item_stall
// rises while it is full. frame_stall holds the output register and, once
// the queue fills, stalls the item side. reset clears the frame state, the
// queue, the output valid and the key; the block is ready right after it.
module checksummed_frame_builder #(
	parameter int MAX_PAYLOAD = 253,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  cfb_pkg::in_item_t  item,
	output logic               frame_valid,
	input  logic               frame_stall,
	output cfb_pkg::out_item_t frame,
	input  logic               key_we,
	input  logic [7:0]         key_wdata
);
	import cfb_pkg::*;

	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_nempty;
	qent_t push_ent;
	qent_t head;

	cfb_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.push       (push),
		.push_ent   (push_ent),
		.q_full     (q_full)
	);

	cfb_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.nempty   (q_nempty),
		.full     (q_full)
	);

	cfb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key_we      (key_we),
		.key_wdata   (key_wdata),
		.head        (head),
		.nempty      (q_nempty),
		.pop         (pop),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame)
	);

endmodule
